### hw/rtl/flsa_pkg.sv
`default_nettype none

package flsa_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 256;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int LINK_W     = ADDR_W + 1;
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_DEPTH);

    // Field widths
    localparam int SLOT_W = 8;
    localparam int CNT_W  = 9;
    localparam int SIZE_W = 13;
    localparam int OFFS_W = 20;

    // Slot size limits (one link word at least)
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
    localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(256);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Register indexes
    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic REG_SLOT_SIZE  = 1'b1;

    // One stage of the offset multiply chain
    typedef struct packed {
        logic              valid;
        logic              granted;
        logic [SLOT_W-1:0] slot_index;
        logic [SLOT_W-1:0] rem;
        logic [OFFS_W-1:0] size_sh;
        logic [OFFS_W-1:0] acc;
    } cell_t;

    // Link memory write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    // Link memory read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } link_rd_t;

    // Link value of an entry that was not written since the last rebuild
    function automatic logic [LINK_W-1:0] link_reset(input logic [ADDR_W-1:0] a);
        logic [LINK_W-1:0] r;
        if (a == '0)
        begin
            r = LINK_END;
        end
        else
        begin
            r = {1'b0, a} - LINK_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/flsa_mul_cell.sv
`default_nettype none

module flsa_mul_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire flsa_pkg::cell_t   prev,
    output flsa_pkg::cell_t        cur
);

    logic            valid_reg;
    flsa_pkg::cell_t data_reg;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev.valid;
        end
    end

    // Add one partial product and shift toward the next bit
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg.valid      <= prev.valid;
            data_reg.granted    <= prev.granted;
            data_reg.slot_index <= prev.slot_index;
            data_reg.rem        <= prev.rem >> 1;
            data_reg.size_sh    <= prev.size_sh << 1;
            data_reg.acc        <= prev.acc + (prev.rem[0] ? prev.size_sh : '0);
        end
    end

    always_comb
    begin
        cur       = data_reg;
        cur.valid = valid_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/flsa_link_mem.sv
`default_nettype none

module flsa_link_mem (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire flsa_pkg::link_wr_t            wr,
    input  wire flsa_pkg::link_rd_t            rd,
    output logic [flsa_pkg::LINK_W-1:0]        rd_link
);

    logic [flsa_pkg::LINK_W-1:0] link_mem [flsa_pkg::POOL_DEPTH];
    logic [flsa_pkg::POOL_DEPTH-1:0] vld_reg;
    logic [flsa_pkg::LINK_W-1:0] mem_q_reg;
    logic                        rd_vld_reg;
    logic [flsa_pkg::ADDR_W-1:0] rd_addr_reg;

    // Write and read the link array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            link_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q_reg <= link_mem[rd.addr];
        end
    end

    // Track entries written since the last rebuild
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Capture the read address and its valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else if (rd.en)
        begin
            rd_vld_reg  <= vld_reg[rd.addr];
            rd_addr_reg <= rd.addr;
        end
    end

    // Fall back to the chained value for unwritten entries
    assign rd_link = rd_vld_reg ? mem_q_reg : flsa_pkg::link_reset(rd_addr_reg);

endmodule

`default_nettype wire

### hw/rtl/free_list_slot_allocator.sv
// Fixed-size slot pool kept as a LIFO linked free list of up to 256 slots. A free
// request (command 1) pushes the slot and gives no result; a slot at or above
// slot_count is dropped. An alloc request (command 0) pops the head: when the pool
// holds a slot it passes through the POP state, where no request is taken, because
// the link of the new head comes from the registered read port of the link memory;
// on an empty pool it stays idle and returns granted 0. Every alloc result leaves
// through a chain of eight shift-and-add cells that forms slot_index times
// slot_size, and the chain stalls as a whole while the output waits. Writing
// slot_count rebuilds the list at once (per-entry valid bits, no clearing pass);
// slot_count above 256 counts as 256, slot_size is held to 16..4096.
// The APB port has no wait states; registers sit at byte addresses 0 and 4.
`default_nettype none

module free_list_slot_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          command,
    input  wire logic [flsa_pkg::SLOT_W-1:0]   slot,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               granted,
    output logic [flsa_pkg::SLOT_W-1:0]        slot_index,
    output logic [flsa_pkg::OFFS_W-1:0]        byte_offset,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                          state_reg, state_next;
    logic [flsa_pkg::LINK_W-1:0]   head_reg, head_next;
    logic [flsa_pkg::CNT_W-1:0]    slot_count_reg;
    logic [flsa_pkg::SIZE_W-1:0]   slot_size_reg;
    logic [flsa_pkg::CNT_W-1:0]    live_count;
    logic [flsa_pkg::CNT_W-1:0]    new_count;
    logic [flsa_pkg::SIZE_W-1:0]   live_size;
    logic                          cfg_wr;
    logic                          cfg_count_wr;
    logic                          accept;
    logic                          is_alloc;
    logic                          head_empty;
    logic                          free_ok;
    logic                          chain_adv;
    logic [flsa_pkg::LINK_W-1:0]   rd_link;
    flsa_pkg::link_wr_t            link_wr;
    flsa_pkg::link_rd_t            link_rd;
    flsa_pkg::cell_t               inject;
    flsa_pkg::cell_t               chain [flsa_pkg::SLOT_W];

    // Decode configuration writes
    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign cfg_count_wr = cfg_wr && (paddr[2] == flsa_pkg::REG_SLOT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= flsa_pkg::CNT_RESET;
            slot_size_reg  <= flsa_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == flsa_pkg::REG_SLOT_COUNT)
            begin
                slot_count_reg <= pwdata[flsa_pkg::CNT_W-1:0];
            end
            else
            begin
                slot_size_reg <= pwdata[flsa_pkg::SIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == flsa_pkg::REG_SLOT_SIZE)
                  ? {{(32-flsa_pkg::SIZE_W){1'b0}}, slot_size_reg}
                  : {{(32-flsa_pkg::CNT_W){1'b0}}, slot_count_reg};

    // Clamp count and size to their usable ranges
    always_comb
    begin
        if (slot_count_reg > flsa_pkg::CNT_W'(flsa_pkg::POOL_DEPTH))
        begin
            live_count = flsa_pkg::CNT_W'(flsa_pkg::POOL_DEPTH);
        end
        else
        begin
            live_count = slot_count_reg;
        end

        if (pwdata[flsa_pkg::CNT_W-1:0] > flsa_pkg::CNT_W'(flsa_pkg::POOL_DEPTH))
        begin
            new_count = flsa_pkg::CNT_W'(flsa_pkg::POOL_DEPTH);
        end
        else
        begin
            new_count = pwdata[flsa_pkg::CNT_W-1:0];
        end

        if (slot_size_reg < flsa_pkg::SIZE_MIN)
        begin
            live_size = flsa_pkg::SIZE_MIN;
        end
        else if (slot_size_reg > flsa_pkg::SIZE_MAX)
        begin
            live_size = flsa_pkg::SIZE_MAX;
        end
        else
        begin
            live_size = slot_size_reg;
        end
    end

    // Request handshake
    assign chain_adv  = !chain[flsa_pkg::SLOT_W-1].valid || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && chain_adv;
    assign accept     = in_valid && in_ready;
    assign is_alloc   = (command == flsa_pkg::CMD_ALLOC);
    assign head_empty = (head_reg == flsa_pkg::LINK_END);
    assign free_ok    = ({1'b0, slot} < live_count);

    // Push on free, read the next link on a granted alloc
    always_comb
    begin
        link_wr.en   = accept && !is_alloc && free_ok;
        link_wr.addr = flsa_pkg::ADDR_W'(slot);
        link_wr.data = head_reg;
        link_rd.en   = accept && is_alloc && !head_empty;
        link_rd.addr = head_reg[flsa_pkg::ADDR_W-1:0];
    end

    flsa_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_count_wr),
        .wr      (link_wr),
        .rd      (link_rd),
        .rd_link (rd_link)
    );

    // Sequence head updates
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (link_wr.en)
                begin
                    head_next = flsa_pkg::LINK_W'(slot);
                end
                else if (link_rd.en)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                head_next  = rd_link;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_count_wr)
        begin
            state_next = ST_IDLE;
            if (new_count == '0)
            begin
                head_next = flsa_pkg::LINK_END;
            end
            else
            begin
                head_next = flsa_pkg::LINK_W'(new_count - flsa_pkg::CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= flsa_pkg::LINK_W'(flsa_pkg::POOL_DEPTH - 1);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
        end
    end

    // Feed an alloc result into the multiply chain
    always_comb
    begin
        inject.valid      = accept && is_alloc;
        inject.granted    = !head_empty;
        inject.slot_index = head_empty ? '0 : head_reg[flsa_pkg::SLOT_W-1:0];
        inject.rem        = head_empty ? '0 : head_reg[flsa_pkg::SLOT_W-1:0];
        inject.size_sh    = flsa_pkg::OFFS_W'(live_size);
        inject.acc        = '0;
    end

    // Build the shift-and-add chain, one cell per index bit
    for (genvar gi = 0; gi < flsa_pkg::SLOT_W; gi++)
    begin : g_cell
        if (gi == 0)
        begin : g_first
            flsa_mul_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (chain_adv),
                .prev  (inject),
                .cur   (chain[gi])
            );
        end
        else
        begin : g_rest
            flsa_mul_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (chain_adv),
                .prev  (chain[gi-1]),
                .cur   (chain[gi])
            );
        end
    end

    // Drive the result channel from the last cell
    assign out_valid   = chain[flsa_pkg::SLOT_W-1].valid;
    assign granted     = chain[flsa_pkg::SLOT_W-1].granted;
    assign slot_index  = chain[flsa_pkg::SLOT_W-1].slot_index;
    assign byte_offset = chain[flsa_pkg::SLOT_W-1].acc;

endmodule

`default_nettype wire

### hw/rtl/flsa_checker.sv
`default_nettype none

module flsa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          granted,
    input wire logic [flsa_pkg::SLOT_W-1:0]   slot_index,
    input wire logic [flsa_pkg::OFFS_W-1:0]   byte_offset
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({granted, slot_index, byte_offset}))
        else $error("result changed while stalled");

    // Drop index and offset on an empty pool
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> slot_index == '0 && byte_offset == '0)
        else $error("null result carries data");

    // Slot zero sits at offset zero
    a_slot0_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted && slot_index == '0 |-> byte_offset == '0)
        else $error("slot zero has nonzero offset");

    // Offsets are at least one link word per slot
    a_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |->
            byte_offset >= {{(flsa_pkg::OFFS_W-flsa_pkg::SLOT_W-4){1'b0}}, slot_index, 4'b0})
        else $error("offset below slot index times minimum size");

endmodule

bind free_list_slot_allocator flsa_checker u_flsa_checker (.*);

`default_nettype wire

### tb/sv/free_list_slot_allocator_test.sv
`timescale 1ns / 1ps

module free_list_slot_allocator_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_LEN      = 400;
    localparam int SEG_ITEMS     = 125;

    typedef struct packed {
        logic                        cmd;
        logic [flsa_pkg::SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic                        granted;
        logic [flsa_pkg::SLOT_W-1:0] slot_index;
        logic [flsa_pkg::OFFS_W-1:0] byte_offset;
    } pool_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        command = flsa_pkg::CMD_ALLOC;
    logic [flsa_pkg::SLOT_W-1:0] slot = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        granted;
    logic [flsa_pkg::SLOT_W-1:0] slot_index;
    logic [flsa_pkg::OFFS_W-1:0] byte_offset;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [2:0]                  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Shadow pool state and registers
    logic [flsa_pkg::LINK_W-1:0] link_mem [flsa_pkg::POOL_DEPTH];
    logic [flsa_pkg::LINK_W-1:0] pool_head;
    logic [flsa_pkg::CNT_W-1:0]  cfg_count;
    logic [flsa_pkg::SIZE_W-1:0] cfg_size;

    req_t                        pend_q[$];
    pool_result_t                grant_q[$];
    logic [flsa_pkg::SLOT_W-1:0] held_q[$];

    int                tx_idle_pct = 34;
    int                rx_idle_pct = 86;
    logic              req_taken = 1'b0;
    bit                hold_go = 1'b0;
    bit                hold_used = 1'b0;
    int                hold_left = 0;
    int                mismatches = 0;
    int unsigned       cycle_count = 0;

    free_list_slot_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .granted     (granted),
        .slot_index  (slot_index),
        .byte_offset (byte_offset),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Slot count in use, saturated to the pool depth
    function automatic int eff_count();
        return (int'(cfg_count) > flsa_pkg::POOL_DEPTH) ? flsa_pkg::POOL_DEPTH
                                                         : int'(cfg_count);
    endfunction

    // Slot size held to one link word at least and 4096 bytes at most
    function automatic int eff_size();
        int sz;
        sz = int'(cfg_size);
        if (sz < int'(flsa_pkg::SIZE_MIN))
        begin
            sz = int'(flsa_pkg::SIZE_MIN);
        end
        else if (sz > int'(flsa_pkg::SIZE_MAX))
        begin
            sz = int'(flsa_pkg::SIZE_MAX);
        end
        return sz;
    endfunction

    // Chain slots count-1 down to 0
    task automatic pool_rebuild();
        int n;
        n = eff_count();
        for (int i = 0; i < flsa_pkg::POOL_DEPTH; i++)
        begin
            link_mem[i] = (i == 0) ? flsa_pkg::LINK_END : flsa_pkg::LINK_W'(i - 1);
        end
        pool_head = (n == 0) ? flsa_pkg::LINK_END : flsa_pkg::LINK_W'(n - 1);
    endtask

    // Apply one accepted request to the shadow pool
    task automatic pool_step(input logic cmd, input logic [flsa_pkg::SLOT_W-1:0] s);
        pool_result_t r;
        logic [flsa_pkg::LINK_W-1:0] got;
        r = '0;
        if (cmd == flsa_pkg::CMD_FREE)
        begin
            if (int'(s) < eff_count())
            begin
                link_mem[s] = pool_head;
                pool_head = {1'b0, s};
            end
        end
        else
        begin
            if (int'(pool_head) < flsa_pkg::POOL_DEPTH)
            begin
                got = pool_head;
                pool_head = link_mem[got[flsa_pkg::ADDR_W-1:0]];
                r.granted = 1'b1;
                r.slot_index = got[flsa_pkg::SLOT_W-1:0];
                r.byte_offset = flsa_pkg::OFFS_W'(int'(got) * eff_size());
            end
            grant_q.insert(grant_q.size(), r);
        end
    endtask

    task automatic note_mismatch(input string what, input pool_result_t want);
        if (mismatches < 10)
        begin
            $display("%0t: %s: expected granted %0d index %0d offset %0d,",
                     $time, what, want.granted, want.slot_index, want.byte_offset,
                     " got granted %0d index %0d offset %0d",
                     granted, slot_index, byte_offset);
        end
        mismatches++;
    endtask

    // Track requests taken and check results against the shadow pool
    always @(posedge clk)
    begin : watch
        pool_result_t want;
        req_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            pool_step(command, slot);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
            begin
                note_mismatch("result with none pending", '0);
            end
            else
            begin
                want = grant_q.pop_front();
                if (want.granted !== granted || want.slot_index !== slot_index
                    || want.byte_offset !== byte_offset)
                begin
                    note_mismatch("result mismatch", want);
                end
                if (want.granted)
                begin
                    held_q.insert(held_q.size(), want.slot_index);
                end
            end
        end
    end

    // Offer the next request, hold it until taken
    always @(negedge clk)
    begin : drive
        req_t nxt;
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                nxt = pend_q.pop_front();
                in_valid <= 1'b1;
                command <= nxt.cmd;
                slot <= nxt.slot;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side, once for a long stretch
    always @(negedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic push_req(input logic cmd, input int s);
        req_t r;
        r.cmd = cmd;
        r.slot = flsa_pkg::SLOT_W'(s);
        pend_q.insert(pend_q.size(), r);
    endtask

    // Write a register with a setup and an access cycle
    task automatic reg_write(input logic idx, input int unsigned value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 3'(4 * int'(idx));
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == flsa_pkg::REG_SLOT_COUNT)
        begin
            cfg_count = flsa_pkg::CNT_W'(value);
            pool_rebuild();
            held_q.delete();
        end
        else
        begin
            cfg_size = flsa_pkg::SIZE_W'(value);
        end
    endtask

    // Wait until every request is taken and every result is back
    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || grant_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly alloc/free pairs on slots actually held, with some noise
    task automatic feed(input int n, input int alloc_pct);
        int made;
        int pick;
        int idx;
        req_t r;
        made = 0;
        while (made < n)
        begin
            while (pend_q.size() >= 4)
            begin
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (held_q.size() == 0 || pick < alloc_pct)
            begin
                r.cmd = flsa_pkg::CMD_ALLOC;
                r.slot = flsa_pkg::SLOT_W'($urandom);
                made++;
            end
            else
            begin
                r.cmd = flsa_pkg::CMD_FREE;
                pick = $urandom_range(0, 99);
                idx = $urandom_range(0, held_q.size() - 1);
                if (pick < 80)
                begin
                    r.slot = held_q[idx];
                    held_q.delete(idx);
                    made++;
                end
                else if (pick < 88)
                begin
                    // double free of a slot still held
                    r.slot = held_q[idx];
                    made++;
                end
                else
                begin
                    r.slot = flsa_pkg::SLOT_W'($urandom_range(0, 255));
                    if (int'(r.slot) < eff_count())
                    begin
                        made++;
                    end
                end
            end
            pend_q.insert(pend_q.size(), r);
        end
    endtask

    // One idling pattern over several register settings
    task automatic run_phase(input int tx_pct, input int rx_pct, input bit squeeze);
        int unsigned cnt;
        int unsigned sz;
        int alloc_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            wait_drained();
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            case ($urandom_range(0, 5))
                0: cnt = 1;
                1: cnt = $urandom_range(2, 8);
                2: cnt = $urandom_range(9, 64);
                3: cnt = $urandom_range(1, 256);
                4: cnt = 256;
                default: cnt = $urandom_range(257, 511);
            endcase
            case ($urandom_range(0, 5))
                0: sz = 16;
                1: sz = 4096;
                2: sz = $urandom_range(0, 15);
                3: sz = $urandom_range(4097, 8191);
                4: sz = $urandom_range(16, 4096);
                default: sz = $urandom_range(0, 8191);
            endcase
            case ($urandom_range(0, 3))
                0: alloc_pct = 30;
                1: alloc_pct = 50;
                2: alloc_pct = 70;
                default: alloc_pct = 90;
            endcase
            reg_write(flsa_pkg::REG_SLOT_SIZE, sz);
            reg_write(flsa_pkg::REG_SLOT_COUNT, cnt);
            if (squeeze && seg == 0)
            begin
                alloc_pct = 70;
                hold_go = 1'b1;
            end
            feed(SEG_ITEMS, alloc_pct);
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("free_list_slot_allocator_test: done, errors");
        $finish;
    end

    initial
    begin
        cfg_count = flsa_pkg::CNT_RESET;
        cfg_size = flsa_pkg::SIZE_RESET;
        pool_rebuild();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Reset list: top slots, then push back and pop again
        push_req(flsa_pkg::CMD_ALLOC, 255);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_FREE, 254);
        push_req(flsa_pkg::CMD_FREE, 255);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        wait_drained();

        // Zero slots: every alloc fails, frees dropped
        reg_write(flsa_pkg::REG_SLOT_COUNT, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_FREE, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        wait_drained();

        // One slot, size below minimum: empty pool, double free, out of range free
        reg_write(flsa_pkg::REG_SLOT_SIZE, 0);
        reg_write(flsa_pkg::REG_SLOT_COUNT, 1);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_FREE, 0);
        push_req(flsa_pkg::CMD_FREE, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_FREE, 200);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        wait_drained();

        // Count and size above range: saturate, widest offset
        reg_write(flsa_pkg::REG_SLOT_COUNT, 511);
        reg_write(flsa_pkg::REG_SLOT_SIZE, 8191);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        push_req(flsa_pkg::CMD_FREE, 128);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        wait_drained();

        reg_write(flsa_pkg::REG_SLOT_SIZE, 15);
        push_req(flsa_pkg::CMD_ALLOC, 0);
        wait_drained();
        reg_write(flsa_pkg::REG_SLOT_SIZE, 4097);
        push_req(flsa_pkg::CMD_ALLOC, 0);

        run_phase(34, 86, 1'b0);
        run_phase(86, 34, 1'b0);
        run_phase(0, 0, 1'b1);
        wait_drained();

        if (mismatches == 0 && grant_q.size() == 0)
        begin
            $display("free_list_slot_allocator_test: done, clean");
        end
        else
        begin
            $display("free_list_slot_allocator_test: done, errors");
        end
        $finish;
    end

endmodule
